// File: rtl/atan2_table_interp_core_macros.svh
// assertion macros for the arctangent core
`ifndef ATAN2_TABLE_INTERP_CORE_MACROS_SVH
`define ATAN2_TABLE_INTERP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define A2TI_ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define A2TI_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("next cycle check failed");
`else
`define A2TI_ASSERT_IMPLY(lbl, a, b)
`define A2TI_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// File: rtl/atan2_ti_pkg.sv
// shared constants, types and the arctangent table of the core
`default_nettype none
package atan2_ti_pkg;

    localparam int InputBits = 16;
    localparam int MagBits = InputBits + 1;
    localparam int QuotBits = 17;
    localparam int AngleBits = 16;
    localparam int AngleFracBits = 13;
    localparam int TableSteps = 256;
    localparam int RomDepth = TableSteps + 1;
    localparam int IdxBits = 9;
    localparam int RatioMin = (65536 + (TableSteps - 1) / 2) / (TableSteps - 1);
    localparam int AccBits = 37;
    localparam int RoundShift = 32 - AngleFracBits;

    localparam logic signed [AccBits-1:0] PiQ32 = 37'sd13493037705;
    localparam logic signed [AccBits-1:0] HalfPiQ32 = 37'sd6746518852;

    typedef struct packed {
        logic zero;
        logic xneg;
        logic yneg;
        logic xgt;
    } t_oct;

    typedef logic [31:0] t_nano [0:RomDepth-1];
    typedef logic [15:0] t_rom [0:RomDepth-1];

    // arctangent in units of 1e-9 rad
    localparam t_nano NanoTab = '{
        32'd0, 32'd3921549, 32'd7842976, 32'd11764160,
        32'd15684990, 32'd19605330, 32'd23525070, 32'd27444090,
        32'd31362260, 32'd35279470, 32'd39195600, 32'd43110530,
        32'd47024130, 32'd50936290, 32'd54846900, 32'd58755820,
        32'd62662950, 32'd66568160, 32'd70471340, 32'd74372380,
        32'd78271140, 32'd82167520, 32'd86061410, 32'd89952670,
        32'd93841210, 32'd97726910, 32'd101609600, 32'd105489300,
        32'd109365800, 32'd113239000, 32'd117108700, 32'd120975000,
        32'd124837600, 32'd128696500, 32'd132551500, 32'd136402600,
        32'd140249600, 32'd144092400, 32'd147931000, 32'd151765200,
        32'd155594800, 32'd159419900, 32'd163240300, 32'd167055900,
        32'd170866500, 32'd174672200, 32'd178472800, 32'd182268100,
        32'd186058200, 32'd189842800, 32'd193622000, 32'd197395600,
        32'd201163400, 32'd204925500, 32'd208681800, 32'd212432000,
        32'd216176200, 32'd219914300, 32'd223646100, 32'd227371600,
        32'd231090700, 32'd234803300, 32'd238509300, 32'd242208600,
        32'd245901200, 32'd249586900, 32'd253265800, 32'd256937600,
        32'd260602400, 32'd264260000, 32'd267910400, 32'd271553500,
        32'd275189200, 32'd278817500, 32'd282438300, 32'd286051400,
        32'd289656900, 32'd293254700, 32'd296844700, 32'd300426800,
        32'd304000900, 32'd307567100, 32'd311125200, 32'd314675200,
        32'd318217000, 32'd321750600, 32'd325275800, 32'd328792700,
        32'd332301200, 32'd335801200, 32'd339292600, 32'd342775500,
        32'd346249700, 32'd349715300, 32'd353172100, 32'd356620100,
        32'd360059300, 32'd363489600, 32'd366911000, 32'd370323400,
        32'd373726800, 32'd377121100, 32'd380506400, 32'd383882500,
        32'd387249400, 32'd390607000, 32'd393955500, 32'd397294600,
        32'd400624400, 32'd403944800, 32'd407255800, 32'd410557400,
        32'd413849600, 32'd417132200, 32'd420405400, 32'd423668900,
        32'd426922900, 32'd430167300, 32'd433402100, 32'd436627200,
        32'd439842600, 32'd443048300, 32'd446244300, 32'd449430600,
        32'd452607000, 32'd455773800, 32'd458930700, 32'd462077800,
        32'd465215000, 32'd468342400, 32'd471460000, 32'd474567600,
        32'd477665400, 32'd480753200, 32'd483831200, 32'd486899200,
        32'd489957300, 32'd493005500, 32'd496043700, 32'd499071900,
        32'd502090200, 32'd505098500, 32'd508096800, 32'd511085200,
        32'd514063600, 32'd517032000, 32'd519990400, 32'd522938800,
        32'd525877200, 32'd528805600, 32'd531724100, 32'd534632500,
        32'd537531000, 32'd540419500, 32'd543298000, 32'd546166600,
        32'd549025100, 32'd551873800, 32'd554712400, 32'd557541100,
        32'd560359900, 32'd563168700, 32'd565967600, 32'd568756600,
        32'd571535700, 32'd574304800, 32'd577064100, 32'd579813500,
        32'd582553100, 32'd585282800, 32'd588002600, 32'd590712600,
        32'd593412800, 32'd596103200, 32'd598783900, 32'd601454700,
        32'd604115800, 32'd606767200, 32'd609408800, 32'd612040700,
        32'd614663000, 32'd617275500, 32'd619878400, 32'd622471700,
        32'd625055400, 32'd627629400, 32'd630193900, 32'd632748800,
        32'd635294200, 32'd637830100, 32'd640356500, 32'd642873400,
        32'd645380800, 32'd647878800, 32'd650367400, 32'd652846600,
        32'd655316500, 32'd657777000, 32'd660228200, 32'd662670100,
        32'd665102700, 32'd667526100, 32'd669940200, 32'd672345200,
        32'd674740900, 32'd677127600, 32'd679505100, 32'd681873500,
        32'd684232800, 32'd686583100, 32'd688924400, 32'd691256700,
        32'd693580000, 32'd695894300, 32'd698199800, 32'd700496400,
        32'd702784100, 32'd705063000, 32'd707333000, 32'd709594300,
        32'd711846900, 32'd714090700, 32'd716325800, 32'd718552300,
        32'd720770100, 32'd722979400, 32'd725180000, 32'd727372100,
        32'd729555700, 32'd731730700, 32'd733897400, 32'd736055500,
        32'd738205300, 32'd740346700, 32'd742479700, 32'd744604500,
        32'd746720900, 32'd748829100, 32'd750929100, 32'd753020800,
        32'd755104400, 32'd757179800, 32'd759247200, 32'd761306400,
        32'd763357600, 32'd765400800, 32'd767436000, 32'd769463300,
        32'd771482600, 32'd773494000, 32'd775497500, 32'd777493200,
        32'd779481100, 32'd781461200, 32'd783433500, 32'd785398300,
        32'd785398300
    };

    // table in q0.16, rounded half up
    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < RomDepth; i++) begin
            rom[i] = 16'((64'(NanoTab[i]) * 64'd65536 + 64'd500000000) / 64'd1000000000);
        end
        return rom;
    endfunction

    localparam t_rom RomQ16 = build_rom();

endpackage
`default_nettype wire

// File: rtl/atan2_table_interp_core.sv
// four-quadrant arctangent by table lookup and linear interpolation
// throughput: one beat per cycle while the output is not stalled, set by the 17-stage divider pipeline
// a stalled output beat holds every stage in place, nothing is dropped
// reset: synchronous active-low, clears all stage valid bits, no table clear
`default_nettype none
`include "atan2_table_interp_core_macros.svh"
module atan2_table_interp_core (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      i_valid,
    output logic                                     o_stall,
    input  wire signed [atan2_ti_pkg::InputBits-1:0] i_x_coord,
    input  wire signed [atan2_ti_pkg::InputBits-1:0] i_y_coord,
    output logic                                     o_valid,
    input  wire                                      i_stall,
    output logic signed [atan2_ti_pkg::AngleBits-1:0] o_angle
);
    import atan2_ti_pkg::*;

    logic               adv;
    logic               w_p_vld, w_d_vld;
    logic [MagBits-1:0] w_small, w_big;
    logic [QuotBits-1:0] w_quot;
    t_oct               w_p_oct, w_d_oct;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    atan2_ti_prep u_prep (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_valid),
        .i_x_coord (i_x_coord),
        .i_y_coord (i_y_coord),
        .o_valid   (w_p_vld),
        .o_small   (w_small),
        .o_big     (w_big),
        .o_oct     (w_p_oct)
    );

    atan2_ti_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (w_p_vld),
        .i_small (w_small),
        .i_big   (w_big),
        .i_oct   (w_p_oct),
        .o_valid (w_d_vld),
        .o_quot  (w_quot),
        .o_oct   (w_d_oct)
    );

    atan2_ti_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (w_d_vld),
        .i_quot  (w_quot),
        .i_oct   (w_d_oct),
        .o_valid (o_valid),
        .o_angle (o_angle)
    );

    `A2TI_ASSERT_IMPLY(a_angle_range, o_valid, (o_angle <= 16'sd25736) && (o_angle >= -16'sd25736))
    `A2TI_ASSERT_NEXT(a_div_hold, o_stall, $stable(w_d_vld) && $stable(w_quot))

endmodule
`default_nettype wire

// File: rtl/atan2_ti_prep.sv
// input stage: magnitudes, signs and operand ordering
`default_nettype none
module atan2_ti_prep (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_adv,
    input  wire                                   i_valid,
    input  wire signed [atan2_ti_pkg::InputBits-1:0] i_x_coord,
    input  wire signed [atan2_ti_pkg::InputBits-1:0] i_y_coord,
    output logic                                  o_valid,
    output logic [atan2_ti_pkg::MagBits-1:0]      o_small,
    output logic [atan2_ti_pkg::MagBits-1:0]      o_big,
    output atan2_ti_pkg::t_oct                    o_oct
);
    import atan2_ti_pkg::*;

    logic [MagBits-1:0] xs, ys, xmag, ymag;
    logic               r_vld;
    logic [MagBits-1:0] r_small, r_big;
    t_oct               r_oct, n_oct;

    always_comb begin
        xs = {i_x_coord[InputBits-1], i_x_coord};
        ys = {i_y_coord[InputBits-1], i_y_coord};
        xmag = i_x_coord[InputBits-1] ? MagBits'(~xs + 1'b1) : xs;
        ymag = i_y_coord[InputBits-1] ? MagBits'(~ys + 1'b1) : ys;
        n_oct.zero = (xmag == '0) && (ymag == '0);
        n_oct.xneg = i_x_coord[InputBits-1];
        n_oct.yneg = i_y_coord[InputBits-1];
        n_oct.xgt  = xmag > ymag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_oct   <= n_oct;
            r_small <= (ymag < xmag) ? ymag : xmag;
            r_big   <= (ymag < xmag) ? xmag : ymag;
        end
    end

    assign o_valid = r_vld;
    assign o_small = r_small;
    assign o_big   = r_big;
    assign o_oct   = r_oct;

endmodule
`default_nettype wire

// File: rtl/atan2_ti_div.sv
// pipelined restoring divider, one quotient bit per stage
`default_nettype none
module atan2_ti_div (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_adv,
    input  wire                               i_valid,
    input  wire [atan2_ti_pkg::MagBits-1:0]   i_small,
    input  wire [atan2_ti_pkg::MagBits-1:0]   i_big,
    input  wire atan2_ti_pkg::t_oct           i_oct,
    output logic                              o_valid,
    output logic [atan2_ti_pkg::QuotBits-1:0] o_quot,
    output atan2_ti_pkg::t_oct                o_oct
);
    import atan2_ti_pkg::*;

    localparam int Stages = QuotBits;

    logic               r_vld [0:Stages-1];
    logic [MagBits-1:0] r_rem [0:Stages-1];
    logic [MagBits-1:0] r_big [0:Stages-1];
    logic [QuotBits-1:0] r_q  [0:Stages-1];
    t_oct               r_oct [0:Stages-1];

    logic               n_ge0;

    assign n_ge0 = i_small >= i_big;

    // integer bit of the quotient
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_adv) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rem[0] <= n_ge0 ? MagBits'(i_small - i_big) : i_small;
            r_big[0] <= i_big;
            r_q[0]   <= {{(QuotBits-1){1'b0}}, n_ge0};
            r_oct[0] <= i_oct;
        end
    end

    for (genvar k = 1; k < Stages; k++) begin : g_stage
        logic [MagBits:0] rem2;
        logic             ge;

        assign rem2 = {r_rem[k-1], 1'b0};
        assign ge   = rem2 >= {1'b0, r_big[k-1]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_rem[k] <= ge ? MagBits'(rem2 - {1'b0, r_big[k-1]}) : MagBits'(rem2);
                r_big[k] <= r_big[k-1];
                r_q[k]   <= {r_q[k-1][QuotBits-2:0], ge};
                r_oct[k] <= r_oct[k-1];
            end
        end
    end

    assign o_valid = r_vld[Stages-1];
    assign o_quot  = r_q[Stages-1];
    assign o_oct   = r_oct[Stages-1];

endmodule
`default_nettype wire

// File: rtl/atan2_ti_interp.sv
// table lookup, interpolation, octant folding and output rounding
`default_nettype none
module atan2_ti_interp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_adv,
    input  wire                                 i_valid,
    input  wire [atan2_ti_pkg::QuotBits-1:0]    i_quot,
    input  wire atan2_ti_pkg::t_oct             i_oct,
    output logic                                o_valid,
    output logic signed [atan2_ti_pkg::AngleBits-1:0] o_angle
);
    import atan2_ti_pkg::*;

    localparam int PBits = QuotBits + 8;

    // lookup stage
    logic [PBits-1:0]   p;
    logic [IdxBits-1:0] idx_raw;
    logic [7:0]         idx;
    logic [15:0]        frac;
    logic [15:0]        t0, t1;

    logic               r_l_vld, r_l_small;
    logic [15:0]        r_l_t0, r_l_frac;
    logic [9:0]         r_l_diff;
    logic [IdxBits-1:0] r_l_z;
    t_oct               r_l_oct;

    always_comb begin
        p = {i_quot, 8'd0};
        p = (p >= PBits'(32768)) ? PBits'(p - PBits'(32768)) : '0;
        idx_raw = p[PBits-1-(PBits-16-IdxBits):16];
        idx  = idx_raw[7:0];
        frac = p[15:0];
        if ((p[PBits-1:16] > (PBits-16)'(TableSteps - 1))) begin
            idx  = 8'(TableSteps - 1);
            frac = '0;
        end
        t0 = RomQ16[{1'b0, idx}];
        t1 = RomQ16[IdxBits'({1'b0, idx}) + 1'b1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l_vld <= 1'b0;
        end else if (i_adv) begin
            r_l_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_l_small <= i_quot < QuotBits'(RatioMin);
            r_l_z     <= i_quot[IdxBits-1:0];
            r_l_t0    <= t0;
            r_l_diff  <= 10'(t1 - t0);
            r_l_frac  <= frac;
            r_l_oct   <= i_oct;
        end
    end

    // multiply stage
    logic               r_m_vld, r_m_small;
    logic [25:0]        r_m_prod;
    logic [15:0]        r_m_t0;
    logic [IdxBits-1:0] r_m_z;
    t_oct               r_m_oct;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (i_adv) begin
            r_m_vld <= r_l_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m_prod  <= r_l_diff * r_l_frac;
            r_m_t0    <= r_l_t0;
            r_m_small <= r_l_small;
            r_m_z     <= r_l_z;
            r_m_oct   <= r_l_oct;
        end
    end

    // fold stage
    logic [26:0]                base_add;
    logic [16:0]                base16;
    logic signed [AccBits-1:0]  b, n_ang;
    logic                       r_f_vld;
    logic signed [AccBits-1:0]  r_f_ang;

    always_comb begin
        base_add = 27'(r_m_prod) + 27'd32768;
        base16 = r_m_small ? 17'(r_m_z) : 17'(r_m_t0 + 16'(base_add[26:16]));
        b = AccBits'({base16, 16'd0});
        if (r_m_oct.zero) begin
            n_ang = '0;
        end else if (r_m_oct.xgt) begin
            if (!r_m_oct.xneg) begin
                n_ang = r_m_oct.yneg ? -b : b;
            end else begin
                n_ang = r_m_oct.yneg ? b - PiQ32 : PiQ32 - b;
            end
        end else begin
            if (!r_m_oct.yneg) begin
                n_ang = r_m_oct.xneg ? HalfPiQ32 + b : HalfPiQ32 - b;
            end else begin
                n_ang = r_m_oct.xneg ? -HalfPiQ32 - b : b - HalfPiQ32;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (i_adv) begin
            r_f_vld <= r_m_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_f_ang <= n_ang;
        end
    end

    // rounding stage, half away from zero
    logic                      neg;
    logic [AccBits-1:0]        mag, rsum;
    logic [AngleBits-1:0]      rnd;
    logic                      r_o_vld;
    logic [AngleBits-1:0]      r_o_angle;

    always_comb begin
        neg  = r_f_ang[AccBits-1];
        mag  = neg ? AccBits'(-r_f_ang) : AccBits'(r_f_ang);
        rsum = mag + (AccBits'(1) << (RoundShift - 1));
        rnd  = AngleBits'(rsum >> RoundShift);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (i_adv) begin
            r_o_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_o_angle <= neg ? AngleBits'(-rnd) : rnd;
        end
    end

    assign o_valid = r_o_vld;
    assign o_angle = r_o_angle;

endmodule
`default_nettype wire
